[src/hta_pkg.sv]
// hta_pkg: shared types, codes and constants of the handle table allocator
// no dependencies

package hta_pkg;

  localparam int NUM_ENTRIES_DEF = 256;

  localparam logic [31:0] FILL_FIRST  = 32'hAAAA_AAAA;
  localparam logic [31:0] FILL_SECOND = 32'hBBBB_BBBB;
  localparam logic [31:0] FILL_THIRD  = 32'hCCCC_CCCC;

  localparam logic [31:0] TYPE_MASK_RST  = 32'h0000_FFFF;
  localparam logic [31:0] ALLOC_TYPE_RST = 32'h0000_0001;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_SET   = 3'd2;
  localparam logic [2:0] KIND_GET   = 3'd3;
  localparam logic [2:0] KIND_FIND  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OUT       = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_TYPE = 2'd1;

  typedef struct packed {
    logic [31:0] type_word;
    logic [31:0] data_first;
    logic [31:0] data_second;
    logic [31:0] data_third;
  } entry_t;

  localparam entry_t FILL_ENTRY = '{
    type_word:   32'h0,
    data_first:  FILL_FIRST,
    data_second: FILL_SECOND,
    data_third:  FILL_THIRD
  };

endpackage

[src/hta_store.sv]
// hta_store: entry memory, one write port and one read port, registered read
// depends on hta_pkg

module hta_store import hta_pkg::*; #(
  parameter int DEPTH = NUM_ENTRIES_DEF,
  parameter int AW    = $clog2(NUM_ENTRIES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/handle_table_allocator.sv]
// handle_table_allocator: top level, operation sequencer around the entry memory
// depends on hta_pkg and hta_store

// Handle table with NUM_ENTRIES entries (type word plus three data words) kept in
// one single-port-read, single-port-write memory. After reset the block sweeps the
// memory, writing free entries with their fill patterns; in_ready stays low during
// that sweep, while cfg writes are taken at any time. Free, set and get pass from
// the accepted beat through one memory read, one check and write back, and a move
// into the output register. Alloc and find issue their first probe from the scan
// state and probe one entry per cycle through the memory read port, then move the
// result into the output register; an alloc with no free entries counted, an
// invalid handle, an unknown kind or a find starting at the last entry or beyond
// skips the memory and goes straight to the output register. One operation is in
// flight at a time; a finished result waits in the output register while the next
// beat is accepted.

module handle_table_allocator import hta_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  input  logic [7:0]           in_handle,
  input  logic [31:0]          in_type_word_in,
  input  logic [31:0]          in_data_in_first,
  input  logic [31:0]          in_data_in_second,
  input  logic [31:0]          in_data_in_third,
  input  logic [31:0]          in_wanted_type,
  input  logic [8:0]           in_start_index,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_handle_out,
  output logic [31:0]          out_type_word_out,
  output logic [31:0]          out_data_out_first,
  output logic [31:0]          out_data_out_second,
  output logic [31:0]          out_data_out_third,
  output logic [8:0]           out_next_index,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX  = AW'(NUM_ENTRIES - 1);
  localparam logic [AW-1:0] FIRST_IDX = AW'(1);
  localparam logic [8:0]    NOT_FOUND_IDX = 9'(NUM_ENTRIES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] cursor_r, cursor_nxt;
  logic [AW-1:0] free_cnt_r, free_cnt_nxt;
  logic [AW-1:0] scan_addr_r, scan_addr_nxt;
  logic [AW-1:0] scan_left_r, scan_left_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [31:0]   tmask_r, tmask_nxt;
  logic [31:0]   atype_r, atype_nxt;

  logic [2:0]    kind_r, kind_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  entry_t        wr_ent_r, wr_ent_nxt;
  logic [31:0]   wanted_r, wanted_nxt;

  logic [1:0]    res_status_r, res_status_nxt;
  logic [7:0]    res_handle_r, res_handle_nxt;
  entry_t        res_ent_r, res_ent_nxt;
  logic [8:0]    res_next_r, res_next_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_handle_r, out_handle_nxt;
  entry_t        out_ent_r, out_ent_nxt;
  logic [8:0]    out_next_r, out_next_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  logic          hdl_ok;
  logic [31:0]   find_first;
  logic [31:0]   rd_masked;
  logic          scan_hit;
  logic [AW-1:0] scan_addr_wrap;
  logic [AW-1:0] cursor_wrap;

  hta_store #(
    .DEPTH (NUM_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign hdl_ok     = (in_handle != 8'd0) && (32'(in_handle) < 32'(NUM_ENTRIES));
  assign find_first = 32'(in_start_index) + 32'd1;
  assign rd_masked  = mem_rdata.type_word & tmask_r;
  assign scan_hit   = pend_r && ((kind_r == KIND_ALLOC) ? (mem_rdata.type_word == 32'h0)
                                                       : (rd_masked == wanted_r));
  assign scan_addr_wrap = (scan_addr_r == LAST_IDX) ? FIRST_IDX : scan_addr_r + 1'b1;
  assign cursor_wrap    = (cursor_r == LAST_IDX) ? FIRST_IDX : cursor_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cursor_nxt     = cursor_r;
    free_cnt_nxt   = free_cnt_r;
    scan_addr_nxt  = scan_addr_r;
    scan_left_nxt  = scan_left_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    tmask_nxt      = tmask_r;
    atype_nxt      = atype_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    wr_ent_nxt     = wr_ent_r;
    wanted_nxt     = wanted_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_ent_nxt    = res_ent_r;
    res_next_nxt   = res_next_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_ent_nxt    = out_ent_r;
    out_next_nxt   = out_next_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = FILL_ENTRY;
    mem_re         = 1'b0;
    mem_raddr      = scan_addr_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_TYPE_MASK:  tmask_nxt = cfg_data;
        CFG_ALLOC_TYPE: atype_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          kind_nxt       = in_kind;
          addr_nxt       = AW'(in_handle);
          wr_ent_nxt     = '{type_word:   in_type_word_in,
                             data_first:  in_data_in_first,
                             data_second: in_data_in_second,
                             data_third:  in_data_in_third};
          wanted_nxt     = in_wanted_type;
          res_status_nxt = ST_OK;
          res_handle_nxt = 8'd0;
          res_ent_nxt    = '0;
          res_next_nxt   = 9'd0;
          pend_nxt       = 1'b0;
          state_nxt      = S_DONE;
          case (in_kind) inside
            KIND_ALLOC: begin
              res_status_nxt = ST_OUT;
              if (free_cnt_r != '0) begin
                scan_addr_nxt = cursor_wrap;
                scan_left_nxt = LAST_IDX;
                state_nxt     = S_SCAN;
              end
            end
            KIND_FREE, KIND_SET, KIND_GET: begin
              if (hdl_ok) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_handle);
                state_nxt = S_CHK;
              end else begin
                res_status_nxt = ST_INVALID;
              end
            end
            KIND_FIND: begin
              res_status_nxt = ST_NOT_FOUND;
              res_next_nxt   = NOT_FOUND_IDX;
              if (find_first < 32'(NUM_ENTRIES)) begin
                scan_addr_nxt = AW'(find_first);
                scan_left_nxt = AW'(32'(NUM_ENTRIES) - find_first);
                state_nxt     = S_SCAN;
              end
            end
            default: res_status_nxt = ST_INVALID;
          endcase
        end
      end

      S_CHK: begin
        state_nxt = S_DONE;
        case (kind_r)
          KIND_FREE: begin
            if (rd_masked == 32'h0) begin
              res_status_nxt = ST_INVALID;
            end else begin
              mem_we       = 1'b1;
              mem_wdata    = FILL_ENTRY;
              free_cnt_nxt = free_cnt_r + 1'b1;
            end
          end
          KIND_SET: begin
            if (rd_masked == 32'h0) begin
              res_status_nxt = ST_INVALID;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = wr_ent_r;
            end
          end
          default: res_ent_nxt = mem_rdata;
        endcase
      end

      S_SCAN: begin
        if (scan_hit) begin
          pend_nxt       = 1'b0;
          res_status_nxt = ST_OK;
          res_handle_nxt = 8'(pend_addr_r);
          state_nxt      = S_DONE;
          if (kind_r == KIND_ALLOC) begin
            mem_we       = 1'b1;
            mem_waddr    = pend_addr_r;
            mem_wdata    = '{type_word: atype_r, default: 32'h0};
            cursor_nxt   = pend_addr_r;
            free_cnt_nxt = free_cnt_r - 1'b1;
          end else begin
            res_next_nxt = 9'(pend_addr_r);
          end
        end else if (scan_left_r == '0) begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = scan_addr_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_addr_r;
          scan_addr_nxt = scan_addr_wrap;
          scan_left_nxt = scan_left_r - 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_ent_nxt    = res_ent_r;
          out_next_nxt   = res_next_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cursor_r    <= FIRST_IDX;
      free_cnt_r  <= LAST_IDX;
      pend_r      <= 1'b0;
      tmask_r     <= TYPE_MASK_RST;
      atype_r     <= ALLOC_TYPE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cursor_r    <= cursor_nxt;
      free_cnt_r  <= free_cnt_nxt;
      pend_r      <= pend_nxt;
      tmask_r     <= tmask_nxt;
      atype_r     <= atype_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r  <= scan_addr_nxt;
    scan_left_r  <= scan_left_nxt;
    pend_addr_r  <= pend_addr_nxt;
    kind_r       <= kind_nxt;
    addr_r       <= addr_nxt;
    wr_ent_r     <= wr_ent_nxt;
    wanted_r     <= wanted_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_ent_r    <= res_ent_nxt;
    res_next_r   <= res_next_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_ent_r    <= out_ent_nxt;
    out_next_r   <= out_next_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_handle_out      = out_handle_r;
  assign out_type_word_out   = out_ent_r.type_word;
  assign out_data_out_first  = out_ent_r.data_first;
  assign out_data_out_second = out_ent_r.data_second;
  assign out_data_out_third  = out_ent_r.data_third;
  assign out_next_index      = out_next_r;

endmodule

[src/hta_checker.sv]
// hta_checker: port-level assertions for the handle table allocator, with its bind
// depends on hta_pkg and handle_table_allocator

module hta_checker import hta_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_handle_out,
  input logic [31:0] out_type_word_out,
  input logic [8:0]  out_next_index
);

  localparam logic [8:0] NOT_FOUND_IDX = 9'(NUM_ENTRIES);

  // clearing sweep holds off input beats right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("beat possible during clearing sweep");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_handle_out) && $stable(out_next_index))
    else $error("result beat changed while stalled");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |->
      out_handle_out == 8'd0 && out_next_index == NOT_FOUND_IDX
      && out_type_word_out == 32'h0)
    else $error("not found beat carries a handle");

  a_failed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OUT || out_status == ST_INVALID) |->
      out_handle_out == 8'd0 && out_next_index == 9'd0 && out_type_word_out == 32'h0)
    else $error("failed beat carries data");

endmodule

bind handle_table_allocator hta_checker #(
  .NUM_ENTRIES (NUM_ENTRIES)
) u_hta_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_handle_out    (out_handle_out),
  .out_type_word_out (out_type_word_out),
  .out_next_index    (out_next_index)
);

[verif/handle_table_allocator_tb.sv]
// handle_table_allocator_tb: self-checking testbench for the handle table allocator
// drives request, result and cfg channels, predicts every result beat in a scoreboard
// depends on hta_pkg and handle_table_allocator

import hta_pkg::*;

typedef struct packed {
  logic [2:0]  kind;
  logic [7:0]  handle;
  logic [31:0] type_word_in;
  logic [31:0] data_in_first;
  logic [31:0] data_in_second;
  logic [31:0] data_in_third;
  logic [31:0] wanted_type;
  logic [8:0]  start_index;
} handle_req_t;

typedef struct packed {
  logic [1:0]  status;
  logic [7:0]  handle_out;
  logic [31:0] type_word_out;
  logic [31:0] data_out_first;
  logic [31:0] data_out_second;
  logic [31:0] data_out_third;
  logic [8:0]  next_index;
} handle_rsp_t;

class handle_table_scoreboard;
  logic [31:0] type_mask;
  logic [31:0] alloc_type;
  logic [31:0] type_words [NUM_ENTRIES_DEF];
  logic [31:0] data_words [NUM_ENTRIES_DEF][3];
  int unsigned cursor;
  int unsigned free_count;
  logic [7:0]  last_alloc;
  handle_rsp_t expected_results [$];
  int          errors;

  function new();
    type_mask  = TYPE_MASK_RST;
    alloc_type = ALLOC_TYPE_RST;
    for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
      type_words[i]    = '0;
      data_words[i][0] = FILL_FIRST;
      data_words[i][1] = FILL_SECOND;
      data_words[i][2] = FILL_THIRD;
    end
    cursor     = 1;
    free_count = NUM_ENTRIES_DEF - 1;
    last_alloc = '0;
    errors     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    if (idx == CFG_TYPE_MASK) begin
      type_mask = value;
    end else if (idx == CFG_ALLOC_TYPE) begin
      alloc_type = value;
    end
  endfunction

  function bit is_live(int unsigned h);
    return (type_words[h] & type_mask) != 0;
  endfunction

  function logic [7:0] live_handle();
    int unsigned n;
    int unsigned pick;
    n = 0;
    for (int i = 1; i < NUM_ENTRIES_DEF; i++) begin
      if (is_live(i)) n++;
    end
    if (n == 0) return '0;
    pick = $urandom_range(n - 1, 0);
    for (int i = 1; i < NUM_ENTRIES_DEF; i++) begin
      if (is_live(i)) begin
        if (pick == 0) return 8'(i);
        pick--;
      end
    end
    return '0;
  endfunction

  function void note_request(handle_req_t req);
    handle_rsp_t rsp;
    bit          handle_ok;
    bit          found;
    int unsigned h;
    rsp        = '0;
    rsp.status = ST_OK;
    h          = req.handle;
    handle_ok  = (h != 0) && (h < NUM_ENTRIES_DEF);
    last_alloc = '0;
    case (req.kind)
      KIND_ALLOC: begin
        rsp.status = ST_OUT;
        found = 1'b0;
        if (free_count != 0) begin
          for (int i = 1; i < NUM_ENTRIES_DEF && !found; i++) begin
            cursor = (cursor + 1 >= NUM_ENTRIES_DEF) ? 1 : cursor + 1;
            if (type_words[cursor] == 0) begin
              found              = 1'b1;
              rsp.status         = ST_OK;
              rsp.handle_out     = 8'(cursor);
              last_alloc         = 8'(cursor);
              free_count--;
              type_words[cursor]    = alloc_type;
              data_words[cursor][0] = '0;
              data_words[cursor][1] = '0;
              data_words[cursor][2] = '0;
            end
          end
        end
      end
      KIND_FREE, KIND_SET: begin
        if (!handle_ok || !is_live(h)) begin
          rsp.status = ST_INVALID;
        end else if (req.kind == KIND_FREE) begin
          type_words[h]    = '0;
          data_words[h][0] = FILL_FIRST;
          data_words[h][1] = FILL_SECOND;
          data_words[h][2] = FILL_THIRD;
          free_count++;
        end else begin
          type_words[h]    = req.type_word_in;
          data_words[h][0] = req.data_in_first;
          data_words[h][1] = req.data_in_second;
          data_words[h][2] = req.data_in_third;
        end
      end
      KIND_GET: begin
        if (!handle_ok) begin
          rsp.status = ST_INVALID;
        end else begin
          rsp.type_word_out   = type_words[h];
          rsp.data_out_first  = data_words[h][0];
          rsp.data_out_second = data_words[h][1];
          rsp.data_out_third  = data_words[h][2];
        end
      end
      KIND_FIND: begin
        rsp.status     = ST_NOT_FOUND;
        rsp.next_index = 9'(NUM_ENTRIES_DEF);
        found = 1'b0;
        for (int i = int'(req.start_index) + 1; i < NUM_ENTRIES_DEF && !found; i++) begin
          if ((type_words[i] & type_mask) == req.wanted_type) begin
            found          = 1'b1;
            rsp.status     = ST_OK;
            rsp.handle_out = 8'(i);
            rsp.next_index = 9'(i);
          end
        end
      end
      default: begin
        rsp.status = ST_INVALID;
      end
    endcase
    expected_results.push_back(rsp);
  endfunction

  function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  function void check_result(handle_rsp_t got);
    handle_rsp_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with no request pending");
      errors++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("handle_out", 32'(want.handle_out), 32'(got.handle_out));
    compare_field("type_word_out", want.type_word_out, got.type_word_out);
    compare_field("data_out_first", want.data_out_first, got.data_out_first);
    compare_field("data_out_second", want.data_out_second, got.data_out_second);
    compare_field("data_out_third", want.data_out_third, got.data_out_third);
    compare_field("next_index", 32'(want.next_index), 32'(got.next_index));
  endfunction

  function void flag_leftovers();
    if (expected_results.size() != 0) begin
      $error("%0d result beats never arrived", expected_results.size());
      errors++;
    end
  endfunction
endclass

module handle_table_allocator_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD_AT   = 60;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = NUM_ENTRIES_DEF + 8;
  localparam logic [2:0] KIND_TOP = '1;

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_kind           = '0;
  logic [7:0]           in_handle         = '0;
  logic [31:0]          in_type_word_in   = '0;
  logic [31:0]          in_data_in_first  = '0;
  logic [31:0]          in_data_in_second = '0;
  logic [31:0]          in_data_in_third  = '0;
  logic [31:0]          in_wanted_type    = '0;
  logic [8:0]           in_start_index    = '0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic [1:0]           out_status;
  logic [7:0]           out_handle_out;
  logic [31:0]          out_type_word_out;
  logic [31:0]          out_data_out_first;
  logic [31:0]          out_data_out_second;
  logic [31:0]          out_data_out_third;
  logic [8:0]           out_next_index;
  logic                 cfg_valid         = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [31:0]          cfg_data          = '0;

  logic        calm = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  handle_table_scoreboard sb = new();

  handle_table_allocator #(
    .NUM_ENTRIES(NUM_ENTRIES_DEF)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_handle          (in_handle),
    .in_type_word_in    (in_type_word_in),
    .in_data_in_first   (in_data_in_first),
    .in_data_in_second  (in_data_in_second),
    .in_data_in_third   (in_data_in_third),
    .in_wanted_type     (in_wanted_type),
    .in_start_index     (in_start_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_handle_out     (out_handle_out),
    .out_type_word_out  (out_type_word_out),
    .out_data_out_first (out_data_out_first),
    .out_data_out_second(out_data_out_second),
    .out_data_out_third (out_data_out_third),
    .out_next_index     (out_next_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic handle_req_t make_req(logic [2:0] kind, logic [7:0] h, logic [31:0] tw,
                                           logic [31:0] d, logic [31:0] wanted,
                                           logic [8:0] start);
    handle_req_t req;
    req.kind           = kind;
    req.handle         = h;
    req.type_word_in   = tw;
    req.data_in_first  = d;
    req.data_in_second = ~d;
    req.data_in_third  = {d[15:0], d[31:16]};
    req.wanted_type    = wanted;
    req.start_index    = start;
    return req;
  endfunction

  function automatic handle_req_t random_req(logic [2:0] kind, logic [7:0] h);
    handle_req_t req;
    req.kind           = kind;
    req.handle         = h;
    req.type_word_in   = ($urandom_range(7, 0) == 0) ? 32'h0 : $urandom;
    req.data_in_first  = $urandom;
    req.data_in_second = $urandom;
    req.data_in_third  = $urandom;
    req.wanted_type    = $urandom_range(1, 0) ?
                         (sb.type_words[sb.live_handle()] & sb.type_mask) : $urandom;
    req.start_index    = ($urandom_range(7, 0) == 0) ? 9'($urandom_range(511, 0)) :
                         9'($urandom_range(NUM_ENTRIES_DEF - 1, 0));
    return req;
  endfunction

  task automatic issue_request(input handle_req_t req);
    in_valid          <= 1'b1;
    in_kind           <= req.kind;
    in_handle         <= req.handle;
    in_type_word_in   <= req.type_word_in;
    in_data_in_first  <= req.data_in_first;
    in_data_in_second <= req.data_in_second;
    in_data_in_third  <= req.data_in_third;
    in_wanted_type    <= req.wanted_type;
    in_start_index    <= req.start_index;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
    if (!calm && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(logic [31:0] mask, logic [31:0] atype);
    write_reg(CFG_TYPE_MASK, mask);
    write_reg(CFG_ALLOC_TYPE, atype);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    issue_request(make_req(KIND_GET, 8'd0, '0, '0, '0, '0));
    issue_request(make_req(KIND_GET, 8'hFF, '0, '0, '0, '0));
    issue_request(make_req(KIND_ALLOC, 8'hFF, '1, '1, '1, '1));
    issue_request(make_req(KIND_ALLOC, 8'd0, '0, '0, '0, '0));
    issue_request(make_req(KIND_SET, 8'd2, '1, '1, '0, '0));
    issue_request(make_req(KIND_GET, 8'd2, '0, '0, '0, '0));
    issue_request(make_req(KIND_SET, 8'd3, '0, '0, '0, '0));
    issue_request(make_req(KIND_SET, 8'd3, 32'h1, 32'h1234_5678, '0, '0));
    issue_request(make_req(KIND_FREE, 8'd3, '0, '0, '0, '0));
    issue_request(make_req(KIND_FREE, 8'd2, '0, '0, '0, '0));
    issue_request(make_req(KIND_GET, 8'd2, '0, '0, '0, '0));
    issue_request(make_req(KIND_FREE, 8'd0, '0, '0, '0, '0));
    issue_request(make_req(KIND_SET, 8'd0, '1, '1, '1, '1));
    issue_request(make_req(KIND_FREE, 8'hFF, '0, '0, '0, '0));
    issue_request(make_req(KIND_FIND, 8'd0, '0, '0, 32'h0, 9'd0));
    issue_request(make_req(KIND_FIND, 8'd0, '0, '0, 32'h1, 9'd0));
    issue_request(make_req(KIND_ALLOC, 8'd0, '0, '0, '0, '0));
    issue_request(make_req(KIND_FIND, 8'd0, '0, '0, 32'h1, 9'd0));
    issue_request(make_req(KIND_FIND, 8'd0, '0, '0, 32'h1, 9'd4));
    issue_request(make_req(KIND_FIND, 8'd0, '0, '0, 32'h0, 9'd255));
    issue_request(make_req(KIND_FIND, 8'd0, '0, '0, 32'h0, 9'd256));
    issue_request(make_req(KIND_FIND, 8'd0, '0, '0, 32'h0, '1));
    for (int k = KIND_FIND + 1; k <= KIND_TOP; k++) begin
      issue_request(random_req(3'(k), 8'($urandom)));
    end
  endtask

  task automatic run_exhaustion();
    repeat (NUM_ENTRIES_DEF + 2) issue_request(random_req(KIND_ALLOC, 8'($urandom)));
    for (int h = 1; h < NUM_ENTRIES_DEF; h++) begin
      if (sb.is_live(h)) issue_request(random_req(KIND_FREE, 8'(h)));
    end
  endtask

  task automatic random_sequence();
    logic [7:0] h;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: begin
        issue_request(random_req(KIND_ALLOC, 8'($urandom)));
        h = sb.last_alloc;
        if (h == 0) h = sb.live_handle();
        issue_request(random_req(KIND_SET, h));
        issue_request(random_req(KIND_GET, h));
        issue_request(random_req(KIND_FIND, 8'($urandom)));
        if ($urandom_range(2, 0) != 0) issue_request(random_req(KIND_FREE, h));
      end
      5, 6: begin
        repeat ($urandom_range(20, 4)) issue_request(random_req(KIND_ALLOC, 8'($urandom)));
      end
      7: begin
        repeat ($urandom_range(20, 4)) issue_request(random_req(KIND_FREE, sb.live_handle()));
      end
      default: begin
        repeat ($urandom_range(6, 1)) begin
          issue_request(random_req(3'($urandom_range(KIND_TOP, 0)), 8'($urandom)));
        end
      end
    endcase
  endtask

  task automatic run_phase(logic [31:0] mask, logic [31:0] atype, int unsigned count);
    int unsigned target;
    wait_until_drained();
    set_config(mask, atype);
    target = requests_sent + count;
    while (requests_sent < target) random_sequence();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_config(TYPE_MASK_RST, ALLOC_TYPE_RST);
    run_directed();
    run_exhaustion();
    run_phase(TYPE_MASK_RST, ALLOC_TYPE_RST, 100);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
    run_phase(32'h0, $urandom, 80);
    run_phase(32'h0000_00FF, 32'h0000_0100, 100);
    run_phase($urandom, 32'h0, 100);
    run_phase($urandom, $urandom, 100);
    calm <= 1'b1;
    run_phase(32'hFFFF_0000, 32'h0001_0000, 120);
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_status, out_handle_out, out_type_word_out, out_data_out_first,
                       out_data_out_second, out_data_out_third, out_next_index});
      results_seen++;
      if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(4, 0) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(3, 1) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
